[rtl/core/ntl_pkg.sv]
// Shared types, constants and reset values for the numeric token lexer.
`default_nettype none
package ntl_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CH_W        = 8;
	localparam int COUNT_W     = 16;
	localparam int OUT_VAL_W   = 32;

	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		CLASS_NAN   = 2'd0,
		CLASS_INT   = 2'd1,
		CLASS_FLOAT = 2'd2
	} token_class_t;

	typedef struct packed {
		logic                   in_token;
		logic [COUNT_W-1:0]     char_count;
		logic                   negative;
		logic                   lead_zero_seen;
		logic                   seen_point;
		logic                   zero_tail;
		logic                   rejected;
		logic [VALUE_WIDTH-1:0] accumulator;
	} tok_state_t;

	typedef struct packed {
		token_class_t           token_class;
		logic [OUT_VAL_W-1:0]   int_value;
		logic [COUNT_W-1:0]     token_length;
	} tok_result_t;

	localparam tok_state_t TOK_IDLE = '{
		in_token:       1'b0,
		char_count:     '0,
		negative:       1'b0,
		lead_zero_seen: 1'b0,
		seen_point:     1'b0,
		zero_tail:      1'b1,
		rejected:       1'b0,
		accumulator:    '0
	};

endpackage
`default_nettype wire

[rtl/core/ntl_step.sv]
// Per-character token state update and result formation (combinational).
`default_nettype none
module ntl_step (
	input  wire ntl_pkg::tok_state_t           cur,
	input  wire logic [ntl_pkg::CH_W-1:0]      ch,
	input  wire logic                          last,
	output ntl_pkg::tok_state_t                nxt,
	output logic                               emit,
	output ntl_pkg::tok_result_t               result
);
	import ntl_pkg::*;

	logic                   is_sep;
	logic                   is_digit;
	logic                   first_num;
	logic                   second_num;
	logic [3:0]             digit;
	logic [VALUE_WIDTH-1:0] acc_mul;
	tok_state_t             upd;
	logic [VALUE_WIDTH-1:0] mag;
	logic [63:0]            mag_wide;

	assign is_sep   = (ch == CH_SPACE) || (ch == CH_NL) || (ch == CH_TAB);
	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign digit    = 4'(ch - CH_ZERO);
	// acc*10 + d as two shifts and two adds
	assign acc_mul  = (cur.accumulator << 3) + (cur.accumulator << 1)
		+ VALUE_WIDTH'(digit);

	// position of first/second character after an optional sign
	assign first_num  = cur.negative ? (cur.char_count == COUNT_W'(1))
		: (cur.char_count == '0);
	assign second_num = cur.negative ? (cur.char_count == COUNT_W'(2))
		: (cur.char_count == COUNT_W'(1));

	always_comb begin
		upd = cur;
		if (!is_sep) begin
			upd.in_token = 1'b1;
			if (cur.char_count != COUNT_MAX) begin
				upd.char_count = cur.char_count + COUNT_W'(1);
			end
			if (cur.char_count == '0 && ch == CH_MINUS) begin
				upd.negative = 1'b1;
			end else begin
				if (first_num && ch == CH_ZERO) begin
					upd.lead_zero_seen = 1'b1;
				end
				if (second_num && cur.lead_zero_seen && ch != CH_POINT) begin
					upd.rejected = 1'b1;
				end
				if (ch == CH_POINT) begin
					if (cur.seen_point) begin
						upd.rejected = 1'b1;
					end
					upd.seen_point = 1'b1;
					upd.zero_tail  = 1'b1;
				end else if (is_digit) begin
					if (digit != 4'd0) begin
						upd.zero_tail = 1'b0;
					end else if (cur.seen_point) begin
						upd.zero_tail = 1'b1;
					end
					upd.accumulator = acc_mul;
				end else begin
					upd.rejected = 1'b1;
				end
			end
		end
	end

	assign emit = (is_sep || last) && upd.in_token;
	assign nxt  = emit ? TOK_IDLE : upd;

	assign mag      = upd.negative ? (~upd.accumulator + VALUE_WIDTH'(1))
		: upd.accumulator;
	assign mag_wide = 64'(mag);

	always_comb begin
		result.token_length = upd.char_count;
		if (upd.rejected || (upd.negative && upd.char_count == COUNT_W'(1))
			|| (upd.zero_tail && upd.char_count > COUNT_W'(1))) begin
			result.token_class = CLASS_NAN;
		end else if (upd.seen_point) begin
			result.token_class = CLASS_FLOAT;
		end else begin
			result.token_class = CLASS_INT;
		end
		result.int_value = (result.token_class == CLASS_INT)
			? mag_wide[OUT_VAL_W-1:0] : '0;
	end

endmodule
`default_nettype wire

[rtl/core/numeric_token_lexer_core.sv]
// Top level of the numeric token lexer: input register, token state, result register.
// Path: the word ending a token passes the input register, then the result register.
// Throughput: one character word per cycle, except that a token-ending word waits
//   while the result register is full and not drained; the state update is a single
//   shift-add and flag logic between the input register and the result register.
// Reset: arst_n clears the valid flags and returns the token state to idle.
`default_nettype none
module numeric_token_lexer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// character stream in
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  wire logic        s_axis_tlast,   // last character of the text
	// token results out
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // [31:0] int_value, [47:32] token_length
	output logic [1:0]       m_axis_tuser    // [1:0] token_class
);
	import ntl_pkg::*;

	// input register stage
	logic            valid_s1;
	logic [CH_W-1:0] ch_s1;
	logic            last_s1;

	// running token state
	tok_state_t      state_q;
	tok_state_t      state_nxt;
	logic            emit;
	tok_result_t     result;

	// result register
	logic            out_valid_q;
	tok_result_t     out_q;

	logic            out_free;
	logic            advance;

	ntl_step u_step (
		.cur    (state_q),
		.ch     (ch_s1),
		.last   (last_s1),
		.nxt    (state_nxt),
		.emit   (emit),
		.result (result)
	);

	// The result register is free if empty or being drained this cycle.
	// A character that ends no token advances regardless of the output side.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!emit || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// token state moves only when the buffered character is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOK_IDLE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.token_length, out_q.int_value};
	assign m_axis_tuser  = out_q.token_class;

endmodule
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for numeric_token_lexer_core: random character text against a token predictor.
import ntl_pkg::*;

module testbench;

	localparam int CLK_PERIOD     = 8;
	localparam int RESET_CYCLES   = 12;
	localparam int RANDOM_CHARS   = 1550;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic [7:0] ch;
		bit         last;
		int         phase;
	} text_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] ch
	logic        s_axis_tlast = 1'b0;  // last character of the text
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // [31:0] int_value, [47:32] token_length
	logic [1:0]  m_axis_tuser;        // [1:0] token_class

	text_word_t  text_q[$];
	text_word_t  sent_word;
	logic [7:0]  tok_text[$];
	tok_state_t  lex = TOK_IDLE;
	tok_result_t pending_tokens[$];
	tok_result_t front_token;

	int cur_phase = 0;
	int calm_left = 0;
	wire calm = (calm_left != 0);
	bit draining = 1'b0;
	int stuck_cycles = 0;
	int errors = 0;
	int chars_sent = 0;
	int n_int = 0, n_float = 0, n_nan = 0;

	numeric_token_lexer_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Idle mixes: none, sender 75%, receiver 75%, both 36%.
	function automatic int send_idle_pct(int ph);
		case (ph)
			1: return 75;
			3: return 36;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(int ph);
		case (ph)
			2: return 75;
			3: return 36;
			default: return 0;
		endcase
	endfunction

	// Token rules applied one character at a time; a finished token goes to pending_tokens.
	task automatic lex_char(input logic [7:0] c, input bit lst);
		logic [COUNT_W-1:0] pos;
		bit sep;
		tok_result_t res;
		sep = (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
		if (!sep) begin
			pos = lex.char_count;
			lex.in_token = 1'b1;
			if (lex.char_count != COUNT_MAX)
				lex.char_count = lex.char_count + 1'b1;
			if (pos == 0 && c == CH_MINUS) begin
				lex.negative = 1'b1;
			end else begin
				// leading zero may only be followed by a point
				if (pos == (lex.negative ? 1 : 0) && c == CH_ZERO)
					lex.lead_zero_seen = 1'b1;
				if (pos == (lex.negative ? 2 : 1) && lex.lead_zero_seen && c != CH_POINT)
					lex.rejected = 1'b1;
				if (c == CH_POINT) begin
					if (lex.seen_point)
						lex.rejected = 1'b1;
					lex.seen_point = 1'b1;
					lex.zero_tail = 1'b1;
				end else if (c >= CH_ZERO && c <= CH_NINE) begin
					if (c != CH_ZERO)
						lex.zero_tail = 1'b0;
					else if (lex.seen_point)
						lex.zero_tail = 1'b1;
					lex.accumulator = lex.accumulator * 4'd10 + VALUE_WIDTH'(c - CH_ZERO);
				end else begin
					lex.rejected = 1'b1;
				end
			end
		end
		if ((sep || lst) && lex.in_token) begin
			if (lex.rejected || (lex.negative && lex.char_count == 1) ||
			    (lex.zero_tail && lex.char_count > 1))
				res.token_class = CLASS_NAN;
			else if (lex.seen_point)
				res.token_class = CLASS_FLOAT;
			else
				res.token_class = CLASS_INT;
			res.int_value = '0;
			if (res.token_class == CLASS_INT)
				res.int_value = lex.negative ? OUT_VAL_W'(-lex.accumulator)
				                             : OUT_VAL_W'(lex.accumulator);
			res.token_length = lex.char_count;
			pending_tokens.push_back(res);
			lex = TOK_IDLE;
		end
	endtask

	task automatic push_char(input logic [7:0] c, input bit lst, input int ph);
		text_word_t w;
		w.ch = c;
		w.last = lst;
		w.phase = ph;
		text_q.push_back(w);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], 1'b0, 0);
	endtask

	function automatic logic [7:0] rand_digit(int lo);
		return 8'(CH_ZERO + $urandom_range(lo, 9));
	endfunction

	function automatic logic [7:0] rand_separator();
		case ($urandom_range(0, 2))
			0: return CH_SPACE;
			1: return CH_NL;
			default: return CH_TAB;
		endcase
	endfunction

	// Well-formed integer, sometimes long enough to wrap.
	task automatic gen_int();
		int n;
		if ($urandom_range(0, 2) == 0)
			tok_text.push_back(CH_MINUS);
		if ($urandom_range(0, 9) == 0) begin
			tok_text.push_back(CH_ZERO);
		end else begin
			tok_text.push_back(rand_digit(1));
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 4);
			repeat (n) tok_text.push_back(rand_digit(0));
		end
	endtask

	// Well-formed float ending in a nonzero digit.
	task automatic gen_float();
		if ($urandom_range(0, 2) == 0)
			tok_text.push_back(CH_MINUS);
		case ($urandom_range(0, 5))
			0, 1: tok_text.push_back(CH_ZERO);
			2: ;  // no integer part
			default: begin
				tok_text.push_back(rand_digit(1));
				repeat ($urandom_range(0, 3)) tok_text.push_back(rand_digit(0));
			end
		endcase
		tok_text.push_back(CH_POINT);
		repeat ($urandom_range(0, 3)) tok_text.push_back(rand_digit(0));
		tok_text.push_back(rand_digit(1));
	endtask

	task automatic add_random_token(input int ph);
		int kind;
		int n;
		bit end_on_char;
		tok_text.delete();
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			gen_int();
		end else if (kind < 55) begin
			gen_float();
		end else if (kind < 65) begin
			// short corner tokens
			case ($urandom_range(0, 5))
				0: tok_text.push_back(CH_POINT);
				1: tok_text.push_back(CH_MINUS);
				2: tok_text.push_back(CH_ZERO);
				3: begin tok_text.push_back(CH_MINUS); tok_text.push_back(CH_ZERO); end
				4: begin tok_text.push_back(CH_MINUS); tok_text.push_back(CH_POINT); end
				default: begin tok_text.push_back(CH_ZERO); tok_text.push_back(CH_POINT); end
			endcase
		end else if (kind < 85) begin
			// near miss: a good number with one change that usually makes it malformed
			if ($urandom_range(0, 1)) gen_int(); else gen_float();
			case ($urandom_range(0, 4))
				0: tok_text.push_back(CH_POINT);
				1: tok_text.push_back(CH_ZERO);
				2: tok_text.push_front(CH_ZERO);
				3: tok_text[$urandom_range(0, tok_text.size() - 1)] = 8'($urandom_range(0, 255));
				default: tok_text.push_front(CH_MINUS);
			endcase
		end else begin
			repeat ($urandom_range(1, 6)) tok_text.push_back(8'($urandom_range(0, 255)));
		end

		end_on_char = ($urandom_range(0, 11) == 0);
		for (int i = 0; i < tok_text.size(); i++)
			push_char(tok_text[i], end_on_char && (i == tok_text.size() - 1), ph);
		if (!end_on_char) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
			for (int j = 0; j < n; j++)
				push_char(rand_separator(), (j == n - 1) && ($urandom_range(0, 11) == 0), ph);
		end
	endtask

	// Sender: holds a word until taken, then may idle before the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				lex_char(sent_word.ch, sent_word.last);
				chars_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (text_q.size() != 0 &&
				    (calm || $urandom_range(0, 99) >= send_idle_pct(text_q[0].phase))) begin
					sent_word = text_q.pop_front();
					cur_phase <= sent_word.phase;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= sent_word.ch;
					s_axis_tlast  <= sent_word.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= draining || calm ||
			                 ($urandom_range(0, 99) >= recv_stall_pct(cur_phase));
	end

	// Occasional stretches where neither side idles.
	always @(posedge clk) begin
		if (calm_left != 0)
			calm_left <= calm_left - 1;
		else if ($urandom_range(0, 59) == 0)
			calm_left <= $urandom_range(16, 96);
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_tokens.size() == 0) begin
				errors++;
				$error("result word with no token pending: class %0d value %0d length %0d",
				       m_axis_tuser, $signed(m_axis_tdata[31:0]), m_axis_tdata[47:32]);
			end else begin
				front_token = pending_tokens.pop_front();
				if (m_axis_tuser !== front_token.token_class) begin
					errors++;
					$error("token_class: expected %0d, got %0d",
					       front_token.token_class, m_axis_tuser);
				end
				if (m_axis_tdata[31:0] !== front_token.int_value) begin
					errors++;
					$error("int_value: expected %0d, got %0d",
					       $signed(front_token.int_value), $signed(m_axis_tdata[31:0]));
				end
				if (m_axis_tdata[47:32] !== front_token.token_length) begin
					errors++;
					$error("token_length: expected %0d, got %0d",
					       front_token.token_length, m_axis_tdata[47:32]);
				end
				case (front_token.token_class)
					CLASS_INT:   n_int++;
					CLASS_FLOAT: n_float++;
					default:     n_nan++;
				endcase
			end
		end
	end

	// Watchdog: nothing moving on either side for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stuck_cycles <= 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		int base;

		// directed corners
		push_text("-0.5 01\t00\n. - ");  // neg lead-zero float, lead zero, all zeros, lone point/minus
		push_text("1.");
		push_char(CH_SPACE, 1'b1, 0);     // separator marked last closes a token
		push_char(8'hFF, 1'b0, 0);
		push_char(8'h00, 1'b0, 0);
		push_char(CH_SPACE, 1'b0, 0);
		push_char(CH_SPACE, 1'b1, 0);     // separator marked last, nothing open
		push_text("3.");
		push_char(CH_ZERO, 1'b1, 0);      // float ending in zero, closed by last

		base = text_q.size();
		while (text_q.size() - base < RANDOM_CHARS)
			add_random_token(((text_q.size() - base) * 4) / RANDOM_CHARS);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (text_q.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (pending_tokens.size() != 0) @(posedge clk);
		draining <= 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d characters in, %0d tokens checked: %0d integer, %0d float, %0d not a number",
		         chars_sent, n_int + n_float + n_nan, n_int, n_float, n_nan);
		$display("idle mixes none/sender/receiver/both, plus directed corner tokens");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/ntl_pkg.sv
rtl/core/ntl_step.sv
rtl/core/numeric_token_lexer_core.sv
tb/testbench.sv
